### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers around concurrent assertions, clocked on a rising edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the active-low reset is asserted.
`define PBW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Assertion that is checked in every cycle, reset included.
`define PBW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/pbw_pkg.sv
// ----------------------------------------------------------------------------
// pbw_pkg
// Types and fixed constants of the periodic boundary wrap unit.
// ----------------------------------------------------------------------------
package pbw_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_A = 3'd3;  // xx low, yy high
    localparam logic [CFG_IDX_W-1:0] REG_RATE_B = 3'd4;  // zz low, yz high
    localparam logic [CFG_IDX_W-1:0] REG_RATE_C = 3'd5;  // xz low, xy high
    localparam logic [CFG_IDX_W-1:0] REG_CTRL   = 3'd6;

    // Fields of the control register.
    localparam int CTRL_REMAP_BIT = 3;
    localparam int CTRL_MASK_LSB  = 4;

    // Item layout.
    localparam int FIELD_W     = 32;
    localparam int HALF_LSB    = 32;
    localparam int IMG_FLAGS_W = 30;
    localparam int GMASK_W     = 32;
    localparam int POS_LSB     = 0;
    localparam int VEL_LSB     = 3 * FIELD_W;
    localparam int IMG_LSB     = 6 * FIELD_W;
    localparam int GMASK_LSB   = IMG_LSB + IMG_FLAGS_W;
    localparam int S_TDATA_W   = 256;
    localparam int M_TDATA_W   = 224;

    // Which way one dimension wrapped for the current item.
    typedef struct packed {
        logic lower;
        logic upper;
    } dim_flags_t;

endpackage

### src/pbw_dim.sv
// ----------------------------------------------------------------------------
// pbw_dim
// When enabled, wraps one coordinate by one period toward the box [lo, hi) and reports which edges it crossed.
// ----------------------------------------------------------------------------
module pbw_dim import pbw_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] pos_in,
    input  logic signed [COORD_BITS-1:0] lo,
    input  logic signed [COORD_BITS-1:0] hi,
    input  logic signed [COORD_BITS:0]   period,
    output logic signed [COORD_BITS-1:0] pos_out,
    output dim_flags_t                   flags
);

    localparam int SW = COORD_BITS + 2;

    logic signed [SW-1:0]         sum_lo;
    logic signed [SW-1:0]         sum_hi;
    logic signed [COORD_BITS-1:0] pos_mid;
    logic signed [COORD_BITS-1:0] pos_up;
    logic                         lower;
    logic                         upper;

    // Saturate an exact sum to the signed coordinate range.
    function automatic logic [COORD_BITS-1:0] sat(input logic [SW-1:0] v);
        logic [COORD_BITS-1:0] r;
        if ((&v[SW-1:COORD_BITS-1]) || !(|v[SW-1:COORD_BITS-1])) begin
            r = v[COORD_BITS-1:0];
        end else if (v[SW-1]) begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    always_comb begin
        sum_lo  = SW'(pos_in) + SW'(period);
        lower   = en && (pos_in < lo);
        pos_mid = lower ? sat(sum_lo) : pos_in;
        // The upper test sees the position after any lower wrap.
        upper   = en && (pos_mid >= hi);
        sum_hi  = SW'(pos_mid) - SW'(period);
        pos_up  = sat(sum_hi);
        if (upper) begin
            pos_out = (pos_up < lo) ? lo : pos_up;
        end else begin
            pos_out = pos_mid;
        end
        flags.lower = lower;
        flags.upper = upper;
    end

endmodule

### src/periodic_boundary_wrap_unit.sv
// ----------------------------------------------------------------------------
// periodic_boundary_wrap_unit
// Wraps atoms into an orthogonal periodic box, updating image counters and
// remapping velocities of atoms in the deform group.
// ----------------------------------------------------------------------------
//  Channel  | Ports               | Contents
//  ---------+---------------------+-------------------------------------------
//  input    | s_tvalid/tready/... | one atom: position, velocity, images, mask
//  result   | m_tvalid/tready/... | wrapped position, velocity and images
//  config   | cfg_wr_*            | box bounds, edge rates, control
//
// One item is accepted per cycle while the result side is not stalled. Each item
// is held in the input register and then in the result register; the wrap and
// remap logic sits between the two.
// A stalled result holds the result register; the input register still takes
// one item while it is empty and then holds it until the result side frees up.
// Reset is synchronous and clears the configuration registers and the valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module periodic_boundary_wrap_unit import pbw_pkg::*; #(
    parameter int IMAGE_BITS = 10,
    parameter int COORD_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y, in_vel_z,
    //          in_image_flags, atom_group_mask, zero fill
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // m_tdata: out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
    //          out_vel_z, out_image_flags, zero fill
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int CB    = COORD_BITS;
    localparam int IMG_W = 3 * IMAGE_BITS + IMG_FLAGS_W;

    // Configuration.
    logic signed [CB-1:0] box_lo_reg [3];
    logic signed [CB-1:0] box_hi_reg [3];
    logic signed [CB:0]   period_reg [3];
    logic [CB-1:0]        rate_xx_reg, rate_yy_reg, rate_zz_reg;
    logic [CB-1:0]        rate_yz_reg, rate_xz_reg, rate_xy_reg;
    logic [2:0]           periodic_reg;
    logic                 remap_en_reg;
    logic [GMASK_W-1:0]   deform_mask_reg;

    // Pipeline.
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 advance;

    // Datapath.
    logic signed [CB-1:0] pos_in  [3];
    logic signed [CB-1:0] pos_new [3];
    logic [CB-1:0]        vel_in  [3];
    logic [CB-1:0]        vel_new [3];
    dim_flags_t           flags   [3];
    dim_flags_t           vflags  [3];
    logic                 remap;
    logic [IMG_W-1:0]     img_ext;
    logic [IMG_W-1:0]     img_new;
    logic [M_TDATA_W-1:0] result_data;

    // Net rate for one wrap: added on a lower wrap, subtracted on an upper one.
    function automatic logic [CB-1:0] rate_term(input dim_flags_t f,
                                                input logic [CB-1:0] r);
        logic [CB-1:0] t;
        t = '0;
        if (f.lower && !f.upper) begin
            t = r;
        end else if (f.upper && !f.lower) begin
            t = '0 - r;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    for (genvar d = 0; d < 3; d++) begin : g_box
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                box_lo_reg[d] <= '0;
                box_hi_reg[d] <= '0;
                period_reg[d] <= '0;
            end else if (cfg_wr_en && cfg_wr_index == REG_BOX_X + CFG_IDX_W'(d)) begin
                box_lo_reg[d] <= cfg_wr_data[CB-1:0];
                box_hi_reg[d] <= cfg_wr_data[HALF_LSB +: CB];
                // The period is formed from the write data so it is ready at once.
                period_reg[d] <= (CB+1)'($signed(cfg_wr_data[HALF_LSB +: CB]))
                               - (CB+1)'($signed(cfg_wr_data[CB-1:0]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_xx_reg     <= '0;
            rate_yy_reg     <= '0;
            rate_zz_reg     <= '0;
            rate_yz_reg     <= '0;
            rate_xz_reg     <= '0;
            rate_xy_reg     <= '0;
            periodic_reg    <= '0;
            remap_en_reg    <= 1'b0;
            deform_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_RATE_A: begin
                    rate_xx_reg <= cfg_wr_data[CB-1:0];
                    rate_yy_reg <= cfg_wr_data[HALF_LSB +: CB];
                end
                REG_RATE_B: begin
                    rate_zz_reg <= cfg_wr_data[CB-1:0];
                    rate_yz_reg <= cfg_wr_data[HALF_LSB +: CB];
                end
                REG_RATE_C: begin
                    rate_xz_reg <= cfg_wr_data[CB-1:0];
                    rate_xy_reg <= cfg_wr_data[HALF_LSB +: CB];
                end
                REG_CTRL: begin
                    periodic_reg    <= cfg_wr_data[2:0];
                    remap_en_reg    <= cfg_wr_data[CTRL_REMAP_BIT];
                    deform_mask_reg <= cfg_wr_data[CTRL_MASK_LSB +: GMASK_W];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Handshake and pipeline registers
    // ------------------------------------------------------------------------
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= result_data;
        end
    end

    // ------------------------------------------------------------------------
    // Wrap datapath
    // ------------------------------------------------------------------------
    for (genvar d = 0; d < 3; d++) begin : g_dim
        assign pos_in[d] = in_data_reg[POS_LSB + d*FIELD_W +: CB];
        assign vel_in[d] = in_data_reg[VEL_LSB + d*FIELD_W +: CB];

        pbw_dim #(
            .COORD_BITS(COORD_BITS)
        ) u_dim (
            .en      (periodic_reg[d]),
            .pos_in  (pos_in[d]),
            .lo      (box_lo_reg[d]),
            .hi      (box_hi_reg[d]),
            .period  (period_reg[d]),
            .pos_out (pos_new[d]),
            .flags   (flags[d])
        );

        assign vflags[d] = remap ? flags[d] : '0;
    end

    assign remap = remap_en_reg
                && (|(deform_mask_reg & in_data_reg[GMASK_LSB +: GMASK_W]));

    // Each wrap is independent per dimension, so the velocity changes add up.
    assign vel_new[0] = vel_in[0] + rate_term(vflags[0], rate_xx_reg)
                                  + rate_term(vflags[1], rate_xy_reg)
                                  + rate_term(vflags[2], rate_xz_reg);
    assign vel_new[1] = vel_in[1] + rate_term(vflags[1], rate_yy_reg)
                                  + rate_term(vflags[2], rate_yz_reg);
    assign vel_new[2] = vel_in[2] + rate_term(vflags[2], rate_zz_reg);

    // Counters above the 30-bit field are computed and then dropped.
    always_comb begin
        img_ext = IMG_W'(in_data_reg[IMG_LSB +: IMG_FLAGS_W]);
        img_new = img_ext;
        for (int d = 0; d < 3; d++) begin
            if (flags[d].lower && !flags[d].upper) begin
                img_new[d*IMAGE_BITS +: IMAGE_BITS] =
                    img_ext[d*IMAGE_BITS +: IMAGE_BITS] - IMAGE_BITS'(1);
            end else if (flags[d].upper && !flags[d].lower) begin
                img_new[d*IMAGE_BITS +: IMAGE_BITS] =
                    img_ext[d*IMAGE_BITS +: IMAGE_BITS] + IMAGE_BITS'(1);
            end
        end
    end

    always_comb begin
        result_data = '0;
        for (int d = 0; d < 3; d++) begin
            result_data[POS_LSB + d*FIELD_W +: FIELD_W] = FIELD_W'(pos_new[d]);
            result_data[VEL_LSB + d*FIELD_W +: FIELD_W] =
                FIELD_W'($signed(vel_new[d]));
        end
        result_data[IMG_LSB +: IMG_FLAGS_W] = img_new[IMG_FLAGS_W-1:0];
    end

endmodule

### src/pbw_checker.sv
// ----------------------------------------------------------------------------
// pbw_checker
// Port-level checks on the periodic boundary wrap unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbw_checker import pbw_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // No result may be offered in the cycle after a reset.
    `PBW_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A result that waits keeps its valid and its data.
    `PBW_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

    // With the result side taking, an accepted item passes on from the input register to the result register.
    `PBW_ASSERT(a_latency, aclk, aresetn, (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid, "item lost in pipeline")

    // A new result appears only for an item accepted earlier on the input side.
    `PBW_ASSERT(a_no_invent, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2), "result without item")

endmodule

bind periodic_boundary_wrap_unit pbw_checker u_pbw_checker (.*);
